/* rtl/wsd_pkg.sv */
// Package for the WebSocket frame deframer: parse phases, item and result
// types, and the header constants of the frame format.
// Depends on nothing; wsd_parser, wsd_out_stage, the top level and the testbench use it.
`timescale 1ns / 1ps

package wsd_pkg;

	// Parse phase of the frame header.
	typedef enum logic [2:0] {
		PH_B0,
		PH_B1,
		PH_EXT,
		PH_KEY,
		PH_PAY
	} phase_t;

	// One raw frame byte as it arrives.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} item_t;

	// One header summary or one unmasked payload byte.
	typedef struct packed {
		logic        result_kind;
		logic        fin_flag;
		logic [3:0]  frame_opcode;
		logic        masked_flag;
		logic [63:0] declared_length;
		logic [7:0]  payload_byte;
		logic        header_truncated;
		logic        last_of_frame;
	} result_t;

	// Result kinds.
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Header byte fields and length codes.
	localparam logic [7:0] FIN_MASK    = 8'h80;
	localparam logic [7:0] OPCODE_MASK = 8'h0f;
	localparam logic [7:0] LEN_MASK    = 8'h7f;
	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [6:0] LEN_EXT64   = 7'd127;

	// Byte counts of the extended length and masking key fields.
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

/* rtl/wsd_stream_if.sv */
// Valid/ready stream interface used for the byte input and the result output
// of the WebSocket frame deframer. The payload type is a parameter.
// Depends on nothing.
`timescale 1ns / 1ps

interface wsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/wsd_parser.sv */
// Header parser and payload unmasker of the WebSocket frame deframer.
// Holds the parse state and forms at most one result per accepted byte.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  wsd_pkg::item_t  item,
	output logic            res_valid,
	output wsd_pkg::result_t result
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [3:0]  left_q, left_d, left_dec;
	logic [63:0] acc_q, acc_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kidx_q, kidx_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        msk_q, msk_d;
	logic        hdr_done;
	logic        pay_hit;
	logic [7:0]  key_byte;
	logic [7:0]  b;
	logic        fend;

	assign b        = item.frame_byte;
	assign fend     = item.frame_end;
	assign left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;

	// Key byte for the current payload index, most significant byte first.
	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next state and result for the byte at the input.
	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		acc_d     = acc_q;
		key_d     = key_q;
		kidx_d    = kidx_q;
		fin_d     = fin_q;
		op_d      = op_q;
		msk_d     = msk_q;
		hdr_done  = 1'b0;
		pay_hit   = 1'b0;

		unique case (phase_q)
			wsd_pkg::PH_B1: begin
				msk_d = (b & wsd_pkg::FIN_MASK) != 8'd0;
				acc_d = '0;
				if ((b[6:0] & wsd_pkg::LEN_MASK[6:0]) == wsd_pkg::LEN_EXT16) begin
					phase_d = wsd_pkg::PH_EXT;
					left_d  = wsd_pkg::EXT16_BYTES;
				end else if ((b[6:0] & wsd_pkg::LEN_MASK[6:0]) == wsd_pkg::LEN_EXT64) begin
					phase_d = wsd_pkg::PH_EXT;
					left_d  = wsd_pkg::EXT64_BYTES;
				end else begin
					acc_d = {57'd0, b[6:0]};
					if (msk_d) begin
						phase_d = wsd_pkg::PH_KEY;
						left_d  = wsd_pkg::KEY_BYTES;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsd_pkg::PH_EXT: begin
				acc_d  = {acc_q[55:0], b};
				left_d = left_dec;
				if (left_dec == 4'd0) begin
					if (msk_q) begin
						phase_d = wsd_pkg::PH_KEY;
						left_d  = wsd_pkg::KEY_BYTES;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d  = {key_q[23:0], b};
				left_d = left_dec;
				if (left_dec == 4'd0) begin
					hdr_done = 1'b1;
				end
			end
			wsd_pkg::PH_PAY: begin
				pay_hit = 1'b1;
				kidx_d  = kidx_q + 2'd1;
			end
			default: begin
				// First header byte; unused phase codes behave the same way.
				fin_d   = (b & wsd_pkg::FIN_MASK) != 8'd0;
				op_d    = 4'(b & wsd_pkg::OPCODE_MASK);
				msk_d   = 1'b0;
				acc_d   = '0;
				key_d   = '0;
				kidx_d  = '0;
				left_d  = '0;
				phase_d = wsd_pkg::PH_B1;
			end
		endcase

		// Header fields show the frame's values after this byte; a truncated header's length is set below.
		result.fin_flag         = fin_d;
		result.frame_opcode     = op_d;
		result.masked_flag      = msk_d;
		result.declared_length  = acc_d;
		result.result_kind      = wsd_pkg::KIND_HEADER;
		result.payload_byte     = 8'd0;
		result.header_truncated = 1'b0;
		result.last_of_frame    = fend;

		if (pay_hit) begin
			result.result_kind  = wsd_pkg::KIND_PAYLOAD;
			result.payload_byte = b ^ (msk_q ? key_byte : 8'd0);
		end else if (hdr_done) begin
			phase_d = wsd_pkg::PH_PAY;
			kidx_d  = '0;
			left_d  = '0;
		end else if (fend) begin
			// Frame ended inside the header: missing low bytes count as zero.
			result.header_truncated = 1'b1;
			if (phase_d == wsd_pkg::PH_EXT) begin
				result.declared_length = left_d[3] ? 64'd0 : (acc_d << {left_d[2:0], 3'b000});
			end else if (phase_d != wsd_pkg::PH_KEY) begin
				result.declared_length = 64'd0;
			end
		end

		res_valid = fire && (pay_hit || hdr_done || fend);

		// Any frame end returns the parser to the first header byte.
		if (fend) begin
			phase_d = wsd_pkg::PH_B0;
			left_d  = '0;
			acc_d   = '0;
			key_d   = '0;
			kidx_d  = '0;
			fin_d   = 1'b0;
			op_d    = '0;
			msk_d   = 1'b0;
		end
	end

	// Parse state register, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_B0;
			left_q  <= '0;
			acc_q   <= '0;
			key_q   <= '0;
			kidx_q  <= '0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			msk_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			key_q   <= key_d;
			kidx_q  <= kidx_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			msk_q   <= msk_d;
		end
	end

	// A byte that ends a frame leaves the parser waiting for a new header.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fend |=> phase_q == wsd_pkg::PH_B0)
		else $error("frame end did not return the parser to the first header byte");

	// Every byte in the payload phase yields a payload result.
	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == wsd_pkg::PH_PAY |->
		res_valid && result.result_kind == wsd_pkg::KIND_PAYLOAD)
		else $error("payload byte produced no payload result");

endmodule

/* rtl/wsd_out_stage.sv */
// Output register with a skid register for the deframer's result stream.
// Lets a new byte be accepted while a result waits, until the skid register is full.
// Depends on wsd_pkg and wsd_stream_if.
`timescale 1ns / 1ps

module wsd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wsd_pkg::result_t push_data,
	output logic             space,
	wsd_stream_if.source     result_out
);

	logic             out_valid_q;
	logic             skid_valid_q;
	wsd_pkg::result_t out_data_q;
	wsd_pkg::result_t skid_data_q;
	logic             out_free;

	assign out_free         = !out_valid_q || result_out.ready;
	assign space            = !skid_valid_q;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_data_q;

	// Valid flags of the output and skid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload; the skid entry drains before any new result.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	// The skid register is only filled behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	// No result arrives while the skid register is occupied.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full output stage");

	// A skid entry moves to the output when the receiver takes a result.
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && result_out.ready |=>
		out_valid_q && !skid_valid_q && out_data_q == $past(skid_data_q))
		else $error("skid entry was not moved to the output");

endmodule

/* rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer, receive side: header parse and payload unmask.
// Channels: frame_in carries one raw frame byte per request with frame_end
// on the frame's last byte; result_out carries one header summary per frame,
// then one unmasked payload byte per further frame byte.
// Header bytes before the end of the header give no result; a frame that
// ends inside its header gives a header summary with header_truncated set.
// A result is registered in the output stage before it appears on result_out.
// Throughput: one byte per cycle while the skid register is empty; the parse
// state is updated on each taken byte, and the output and skid registers let
// a byte be taken in the same cycle that a waiting result is held.
// Stall: when the receiver holds ready low, one more result is held in the
// skid register (header bytes that give no result are still taken), and
// then frame_in.ready drops until the receiver takes a result.
// Reset: arst_n clears the parse state to the first header byte and empties
// the output stage; no request is lost or repeated across a stall.
// Depends on wsd_pkg, wsd_stream_if, wsd_parser and wsd_out_stage.
`timescale 1ns / 1ps

module websocket_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	wsd_stream_if.sink   frame_in,
	wsd_stream_if.source result_out
);

	logic             fire;
	logic             space;
	logic             res_valid;
	wsd_pkg::result_t result;
	wsd_pkg::item_t   item;

	assign item           = frame_in.data;
	assign frame_in.ready = space;
	assign fire           = frame_in.valid && space;

	// Parse state and result forming.
	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item),
		.res_valid (res_valid),
		.result    (result)
	);

	// Registered result output with skid.
	wsd_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (result),
		.space      (space),
		.result_out (result_out)
	);

endmodule

/* tb/sv/websocket_frame_deframer_tb.sv */
// Self-checking testbench for the WebSocket frame deframer: a directed table of frames, then
// random frames, checked result by result against a byte-level header parser written here.
// Depends on wsd_pkg, wsd_stream_if and websocket_frame_deframer.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

	localparam int unsigned PHASE_ITEMS = 550;
	localparam int unsigned MAX_PRINTED = 200;

	// One row of the directed table; pinned rows carry a header result typed in by hand.
	typedef struct {
		logic [7:0]       frame_byte;
		logic             frame_end;
		bit               pinned;
		wsd_pkg::result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	wsd_stream_if #(.payload_t(wsd_pkg::item_t))   frame_in_if ();
	wsd_stream_if #(.payload_t(wsd_pkg::result_t)) result_if ();

	websocket_frame_deframer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in_if),
		.result_out (result_if)
	);

	// Parser state of the expected behavior.
	wsd_pkg::phase_t hdr_phase;
	logic [3:0]      field_left;
	logic [63:0]     len_acc;
	logic [31:0]     key_word;
	logic [1:0]      key_pos;
	logic            cur_fin;
	logic [3:0]      cur_opcode;
	logic            cur_masked;

	wsd_pkg::result_t expected_results[$];
	stim_row_t        stim_rows[$];
	int unsigned      mismatch_count;
	int unsigned      results_seen;
	int unsigned      bytes_sent;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	bit               pin_active;
	wsd_pkg::result_t pin_value;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Safety net against a hung handshake.
	initial begin
		#2000000;
		$display("[websocket_frame_deframer] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t ns: result %0d: %s", $time, results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic void restart_frame();
		hdr_phase  = wsd_pkg::PH_B0;
		field_left = '0;
		len_acc    = '0;
		key_word   = '0;
		key_pos    = '0;
		cur_fin    = 1'b0;
		cur_opcode = '0;
		cur_masked = 1'b0;
	endfunction

	// A result built from the header values held for the current frame.
	function automatic wsd_pkg::result_t form_result(input logic kind, input logic [63:0] len,
			input logic [7:0] pay, input logic trunc, input logic last);
		wsd_pkg::result_t r;
		r.result_kind      = kind;
		r.fin_flag         = cur_fin;
		r.frame_opcode     = cur_opcode;
		r.masked_flag      = cur_masked;
		r.declared_length  = len;
		r.payload_byte     = pay;
		r.header_truncated = trunc;
		r.last_of_frame    = last;
		return r;
	endfunction

	// Advances the parser by one frame byte; returns 1 when the byte causes a result.
	function automatic bit parse_frame_byte(input logic [7:0] b, input logic e,
			output wsd_pkg::result_t r);
		logic [6:0]  code;
		logic [7:0]  key_byte;
		logic [63:0] part_len;
		bit          header_complete;
		r = '0;
		header_complete = 1'b0;
		case (hdr_phase)
			wsd_pkg::PH_B1: begin
				// The mask bit sits in the same bit position as FIN does in the first byte.
				cur_masked = (b & wsd_pkg::FIN_MASK) != 0;
				code = 7'(b & wsd_pkg::LEN_MASK);
				len_acc = '0;
				if (code == wsd_pkg::LEN_EXT16) begin
					hdr_phase = wsd_pkg::PH_EXT;
					field_left = wsd_pkg::EXT16_BYTES;
				end else if (code == wsd_pkg::LEN_EXT64) begin
					hdr_phase = wsd_pkg::PH_EXT;
					field_left = wsd_pkg::EXT64_BYTES;
				end else begin
					len_acc = 64'(code);
					if (cur_masked) begin
						hdr_phase = wsd_pkg::PH_KEY;
						field_left = wsd_pkg::KEY_BYTES;
					end else begin
						header_complete = 1'b1;
					end
				end
			end
			wsd_pkg::PH_EXT: begin
				len_acc = {len_acc[55:0], b};
				if (field_left != 0)
					field_left--;
				if (field_left == 0) begin
					if (cur_masked) begin
						hdr_phase = wsd_pkg::PH_KEY;
						field_left = wsd_pkg::KEY_BYTES;
					end else begin
						header_complete = 1'b1;
					end
				end
			end
			wsd_pkg::PH_KEY: begin
				key_word = {key_word[23:0], b};
				if (field_left != 0)
					field_left--;
				if (field_left == 0)
					header_complete = 1'b1;
			end
			wsd_pkg::PH_PAY: begin
				// Key bytes are applied most significant first, cycling every four bytes.
				key_byte = cur_masked ? 8'(key_word >> (24 - 8 * int'(key_pos))) : 8'h00;
				r = form_result(wsd_pkg::KIND_PAYLOAD, len_acc, b ^ key_byte, 1'b0, e);
				key_pos++;
				if (e)
					restart_frame();
				return 1'b1;
			end
			default: begin
				restart_frame();
				cur_fin = (b & wsd_pkg::FIN_MASK) != 0;
				cur_opcode = 4'(b & wsd_pkg::OPCODE_MASK);
				hdr_phase = wsd_pkg::PH_B1;
			end
		endcase

		// Header finished on this byte: summary, then payload follows.
		if (header_complete) begin
			r = form_result(wsd_pkg::KIND_HEADER, len_acc, 8'h00, 1'b0, e);
			hdr_phase = wsd_pkg::PH_PAY;
			key_pos = '0;
			field_left = '0;
			if (e)
				restart_frame();
			return 1'b1;
		end
		if (!e)
			return 1'b0;

		// Frame ended inside its header; bytes that never came count as zero.
		part_len = '0;
		if (hdr_phase == wsd_pkg::PH_EXT) begin
			if (field_left < wsd_pkg::EXT64_BYTES)
				part_len = len_acc << (8 * int'(field_left));
		end else if (hdr_phase == wsd_pkg::PH_KEY) begin
			part_len = len_acc;
		end
		r = form_result(wsd_pkg::KIND_HEADER, part_len, 8'h00, 1'b1, 1'b1);
		restart_frame();
		return 1'b1;
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] b, input logic e = 1'b0);
		stim_row_t row;
		row.frame_byte = b;
		row.frame_end  = e;
		row.pinned     = 1'b0;
		row.want       = '0;
		return row;
	endfunction

	// A row whose header result is known by inspection; last_of_frame follows frame_end.
	function automatic stim_row_t header_row(input logic [7:0] b, input logic e,
			input logic fin, input logic [3:0] op, input logic masked,
			input logic [63:0] len, input logic trunc);
		stim_row_t row;
		row.frame_byte = b;
		row.frame_end  = e;
		row.pinned     = 1'b1;
		row.want       = '{result_kind: wsd_pkg::KIND_HEADER, fin_flag: fin,
			frame_opcode: op, masked_flag: masked, declared_length: len,
			payload_byte: 8'h00, header_truncated: trunc, last_of_frame: e};
		return row;
	endfunction

	// Drives one request at the falling edge and holds it until it is taken.
	task automatic push_byte(input logic [7:0] b, input logic e, input bit pinned,
			input wsd_pkg::result_t want);
		wsd_pkg::item_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			frame_in_if.valid <= 1'b0;
			@(negedge clk);
		end
		pin_active = pinned;
		pin_value = want;
		req.frame_byte = b;
		req.frame_end = e;
		frame_in_if.valid <= 1'b1;
		frame_in_if.data <= req;
		do
			@(posedge clk);
		while (!frame_in_if.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Mostly well-formed frames with random content; some cut short, some plain noise.
	task automatic send_random_frame();
		logic [7:0]  frame_q[$];
		logic [6:0]  code;
		logic        masked;
		int unsigned style, sel, ext_n, ext_fill, cut;
		style = $urandom_range(19);
		if (style < 2) begin
			repeat ($urandom_range(1, 3))
				frame_q = {frame_q, 8'($urandom)};
		end else begin
			frame_q = {frame_q, 8'($urandom)};
			masked = 1'($urandom);
			sel = $urandom_range(9);
			if (sel < 6)
				code = 7'($urandom_range(125));
			else if (sel < 8)
				code = wsd_pkg::LEN_EXT16;
			else
				code = wsd_pkg::LEN_EXT64;
			frame_q = {frame_q, {masked, code}};
			ext_n = (code == wsd_pkg::LEN_EXT16) ? 2 : (code == wsd_pkg::LEN_EXT64) ? 8 : 0;
			// Whole extended lengths of zeros or ones reach the field extremes.
			ext_fill = $urandom_range(3);
			repeat (ext_n)
				frame_q = {frame_q, (ext_fill == 0) ? 8'h00 :
					(ext_fill == 1) ? 8'hFF : 8'($urandom)};
			if (masked)
				repeat (4)
					frame_q = {frame_q, 8'($urandom)};
			if (style < 4) begin
				cut = $urandom_range(1, frame_q.size());
				frame_q = frame_q[0:cut-1];
			end else begin
				repeat ($urandom_range(12))
					frame_q = {frame_q, 8'($urandom)};
			end
		end
		foreach (frame_q[i])
			push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
	endtask

	// Receiver side: ready changes at the falling edge.
	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// At each rising edge: predict for a taken request, then check a taken result.
	always @(posedge clk) begin
		wsd_pkg::result_t predicted;
		wsd_pkg::result_t got;
		wsd_pkg::result_t want;
		if (frame_in_if.valid && frame_in_if.ready) begin
			if (parse_frame_byte(frame_in_if.data.frame_byte, frame_in_if.data.frame_end,
					predicted))
				expected_results = {expected_results, pin_active ? pin_value : predicted};
		end
		if (result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (expected_results.size() == 0) begin
				report_mismatch("result arrived with none outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
				check_field("fin_flag", 64'(got.fin_flag), 64'(want.fin_flag));
				check_field("frame_opcode", 64'(got.frame_opcode), 64'(want.frame_opcode));
				check_field("masked_flag", 64'(got.masked_flag), 64'(want.masked_flag));
				check_field("declared_length", got.declared_length, want.declared_length);
				check_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
				check_field("header_truncated", 64'(got.header_truncated),
					64'(want.header_truncated));
				check_field("last_of_frame", 64'(got.last_of_frame),
					64'(want.last_of_frame));
			end
			results_seen++;
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		frame_in_if.valid = 1'b0;
		frame_in_if.data = '0;
		result_if.ready = 1'b0;
		pin_active = 1'b0;
		pin_value = '0;
		mismatch_count = 0;
		results_seen = 0;
		bytes_sent = 0;
		send_idle_pct = 11;
		recv_idle_pct = 76;
		restart_frame();

		stim_rows = '{
			// A frame that ends on its first byte: truncated header, all-ones opcode.
			header_row(8'hFF, 1'b1, 1'b1, 4'hF, 1'b0, 64'd0, 1'b1),
			// A two-byte header that ends the frame, every field zero.
			byte_row(8'h00),
			header_row(8'h00, 1'b1, 1'b0, 4'h0, 1'b0, 64'd0, 1'b0),
			// Masked frame, 16-bit length 65535; the key wraps over five payload bytes.
			byte_row(8'h8A), byte_row(8'hFE), byte_row(8'hFF), byte_row(8'hFF),
			byte_row(8'h01), byte_row(8'h02), byte_row(8'h03),
			header_row(8'h04, 1'b0, 1'b1, 4'hA, 1'b1, 64'hFFFF, 1'b0),
			byte_row(8'hF0), byte_row(8'h0F), byte_row(8'h55), byte_row(8'hAA),
			byte_row(8'h33, 1'b1),
			// A 64-bit length cut after two bytes lands in the high-order part.
			byte_row(8'h8F), byte_row(8'h7F), byte_row(8'hAB),
			header_row(8'hCD, 1'b1, 1'b1, 4'hF, 1'b0, 64'hABCD_0000_0000_0000, 1'b1),
			// The masking key cut after its first byte keeps the 7-bit length.
			byte_row(8'h01), byte_row(8'h85),
			header_row(8'h11, 1'b1, 1'b0, 4'h1, 1'b1, 64'd5, 1'b1),
			// A 64-bit length code with none of its bytes gives length zero.
			byte_row(8'h02),
			header_row(8'h7F, 1'b1, 1'b0, 4'h2, 1'b0, 64'd0, 1'b1)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			push_byte(stim_rows[i].frame_byte, stim_rows[i].frame_end, stim_rows[i].pinned,
				stim_rows[i].want);

		// Three idling profiles: receiver mostly stalled, sender mostly idle, neither.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 76 : 0;
			recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 11 : 0;
			while (bytes_sent < (ph + 1) * PHASE_ITEMS)
				send_random_frame();
		end
		frame_in_if.valid <= 1'b0;

		// Drain, then wait for any stray result.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("[websocket_frame_deframer] OK");
		else
			$display("[websocket_frame_deframer] ERROR");
		$finish;
	end

endmodule

/* websocket_frame_deframer.f */
rtl/wsd_pkg.sv
rtl/wsd_stream_if.sv
rtl/wsd_parser.sv
rtl/wsd_out_stage.sv
rtl/websocket_frame_deframer.sv
tb/sv/websocket_frame_deframer_tb.sv
